@@ sv/bf3_pkg.sv @@
package bf3_pkg;

  // Geometry and build-time constants
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int RANGE_SIGMA = 500;
  localparam int MIN_DIM     = 3;

  localparam int PIX_W = 8;
  localparam int IW_W  = 11;                      // image_width register
  localparam int IH_W  = 13;                      // image_height register
  localparam int WT_W  = 16;                      // Q0.16 weights
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LIN_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WH_W  = LIN_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_WEIGHT = 2'd3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [WT_W-1:0] CENTRE_WEIGHT = 16'hFFFF;

  localparam longint unsigned FX_ONE  = 64'd1 << 40;
  localparam longint unsigned RANGE_M = 64'(2 * RANGE_SIGMA * RANGE_SIGMA);

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel_in;
  } bf3_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } bf3_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MEMWR,
    ST_MUL,
    ST_ADD,
    ST_RED,
    ST_DECIDE,
    ST_ACC,
    ST_DINIT,
    ST_DIV,
    ST_OUT
  } bf3_state_e;

  typedef struct packed {
    logic accept;
    logic mem_read;
    logic mem_write;
    logic adv_in;
    logic lin_mul;
    logic lin_add;
    logic lin_red;
    logic lin_sel;      // 0 input position, 1 output position
    logic lin_store;
    logic decide;
    logic win_shift;
    logic acc_step;
    logic div_init;
    logic div_step;
    logic out_load;
    logic adv_out;
  } bf3_cmd_t;

  typedef struct packed {
    logic is_drain;
    logic lin_fin;
    logic emit;
    logic last_col;
    logic acc_done;
    logic div_done;
    logic out_free;
  } bf3_stat_t;

  typedef logic [WT_W-1:0] bf3_rom_t [256];

  // floor(a/b) by shift and subtract, b > 0
  function automatic longint unsigned fx_div(longint unsigned a, longint unsigned b);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem    = rem - b;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // a*b >> 40 in Q.40
  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return ((a * (b >> 20)) + ((a * (b & 64'hFFFFF)) >> 20)) >> 20;
  endfunction

  // exp(-r/m) in Q.40 by series, r <= m
  function automatic longint unsigned fx_exp_frac(longint unsigned r, longint unsigned m);
    longint unsigned term;
    longint unsigned dv;
    longint unsigned hi;
    longint unsigned q1;
    longint unsigned r1;
    longint unsigned x;
    longint          acc;
    term = FX_ONE;
    acc  = longint'(FX_ONE);
    for (int k = 1; k <= 30; k++) begin
      dv   = m * 64'(k);
      hi   = (term >> 20) * r;
      q1   = fx_div(hi, dv);
      r1   = hi - q1 * dv;
      x    = (r1 << 20) + (term & 64'hFFFFF) * r;
      term = (q1 << 20) + fx_div(x, dv);
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : $unsigned(acc);
  endfunction

  function automatic bf3_rom_t build_range_rom();
    bf3_rom_t        rom;
    longint unsigned e1;
    longint unsigned v;
    longint unsigned n;
    longint unsigned q;
    longint unsigned rounded;
    e1 = fx_exp_frac(64'd1, 64'd1);
    for (int d = 0; d < 256; d++) begin
      n = 64'(d) * 64'(d);
      q = fx_div(n, RANGE_M);
      if (q >= 64'd12) begin
        rom[d] = '0;
      end else begin
        v = fx_exp_frac(n - q * RANGE_M, RANGE_M);
        for (longint unsigned i = 0; i < q; i++) begin
          v = fx_mul(v, e1);
        end
        rounded = (v * 64'd65535 + (64'd1 << 39)) >> 40;
        rom[d]  = (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
      end
    end
    return rom;
  endfunction

  localparam bf3_rom_t RANGE_ROM = build_range_rom();

endpackage

@@ sv/bf3_ctrl.sv @@
module bf3_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bf3_pkg::bf3_stat_t  stat_i,
  output bf3_pkg::bf3_cmd_t   cmd_o
);

  bf3_pkg::bf3_state_e state_q, state_d;
  logic                sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bf3_pkg::ST_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      bf3_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bf3_pkg::ST_READ;
          sel_d   = 1'b0;
        end
      end
      bf3_pkg::ST_READ: begin
        state_d = stat_i.is_drain ? bf3_pkg::ST_MUL : bf3_pkg::ST_MEMWR;
      end
      bf3_pkg::ST_MEMWR: state_d = bf3_pkg::ST_MUL;
      bf3_pkg::ST_MUL:   state_d = bf3_pkg::ST_ADD;
      bf3_pkg::ST_ADD:   state_d = bf3_pkg::ST_RED;
      bf3_pkg::ST_RED: begin
        if (stat_i.lin_fin) begin
          state_d = sel_q ? bf3_pkg::ST_DECIDE : bf3_pkg::ST_MUL;
          sel_d   = 1'b1;
        end
      end
      bf3_pkg::ST_DECIDE: begin
        state_d = stat_i.emit ? bf3_pkg::ST_ACC : bf3_pkg::ST_IDLE;
      end
      bf3_pkg::ST_ACC: begin
        if (stat_i.acc_done) begin
          state_d = bf3_pkg::ST_DINIT;
        end
      end
      bf3_pkg::ST_DINIT: state_d = bf3_pkg::ST_DIV;
      bf3_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = bf3_pkg::ST_OUT;
        end
      end
      bf3_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          state_d = bf3_pkg::ST_IDLE;
        end
      end
      default: state_d = bf3_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.lin_sel = sel_q;
    in_stall_o    = (state_q != bf3_pkg::ST_IDLE);
    case (state_q)
      bf3_pkg::ST_IDLE:  cmd_o.accept = in_valid_i;
      bf3_pkg::ST_READ:  cmd_o.mem_read = 1'b1;
      bf3_pkg::ST_MEMWR: begin
        cmd_o.mem_write = 1'b1;
        cmd_o.adv_in    = 1'b1;
      end
      bf3_pkg::ST_MUL: cmd_o.lin_mul = 1'b1;
      bf3_pkg::ST_ADD: cmd_o.lin_add = 1'b1;
      bf3_pkg::ST_RED: begin
        if (stat_i.lin_fin) begin
          cmd_o.lin_store = 1'b1;
        end else begin
          cmd_o.lin_red = 1'b1;
        end
      end
      bf3_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.emit) begin
          cmd_o.win_shift = !stat_i.last_col;
        end else begin
          cmd_o.win_shift = !stat_i.is_drain;
        end
      end
      bf3_pkg::ST_ACC:   cmd_o.acc_step = 1'b1;
      bf3_pkg::ST_DINIT: cmd_o.div_init = 1'b1;
      bf3_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      bf3_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.adv_out   = 1'b1;
          cmd_o.win_shift = stat_i.last_col;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ sv/bf3_dp.sv @@
module bf3_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  bf3_pkg::bf3_in_t                    in_data_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output bf3_pkg::bf3_out_t                   out_data_o,
  input  bf3_pkg::bf3_cmd_t                   cmd_i,
  output bf3_pkg::bf3_stat_t                  stat_o
);

  localparam int COL_W  = bf3_pkg::COL_W;
  localparam int ROW_W  = bf3_pkg::ROW_W;
  localparam int IW_W   = bf3_pkg::IW_W;
  localparam int IH_W   = bf3_pkg::IH_W;
  localparam int LIN_W  = bf3_pkg::LIN_W;
  localparam int WH_W   = bf3_pkg::WH_W;
  localparam int PIX_W  = bf3_pkg::PIX_W;
  localparam int WT_W   = bf3_pkg::WT_W;
  localparam int RED_TOP = LIN_W - 4;            // wh >= 9, so quotient < 2^(LIN_W-3)
  localparam int K_W    = $clog2(RED_TOP + 1);
  localparam int SW_W   = WT_W + 4;              // nine weights
  localparam int SWP_W  = SW_W + PIX_W;
  localparam int MEM_D  = bf3_pkg::MAX_WIDTH;

  // configuration
  logic [IW_W-1:0] width_q;
  logic [IH_W-1:0] height_q;
  logic [WT_W-1:0] edge_q, corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IW_W'(256);
      height_q <= IH_W'(256);
      edge_q   <= 16'hFFFF;
      corner_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bf3_pkg::CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i[IW_W-1:0];
        bf3_pkg::CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i[IH_W-1:0];
        bf3_pkg::CFG_EDGE_WEIGHT:   edge_q   <= cfg_data_i[WT_W-1:0];
        bf3_pkg::CFG_CORNER_WEIGHT: corner_q <= cfg_data_i[WT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [IW_W-1:0]      eff_w;
  logic [IH_W-1:0]      eff_h;
  logic [IW_W+IH_W-1:0] wh_full;
  logic [WH_W-1:0]      wh;

  always_comb begin
    if (width_q < IW_W'(bf3_pkg::MIN_DIM)) begin
      eff_w = IW_W'(bf3_pkg::MIN_DIM);
    end else if (width_q > IW_W'(bf3_pkg::MAX_WIDTH)) begin
      eff_w = IW_W'(bf3_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q < IH_W'(bf3_pkg::MIN_DIM)) begin
      eff_h = IH_W'(bf3_pkg::MIN_DIM);
    end else if (height_q > IH_W'(bf3_pkg::MAX_HEIGHT)) begin
      eff_h = IH_W'(bf3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  assign wh_full = {{IH_W{1'b0}}, eff_w} * {{IW_W{1'b0}}, eff_h};
  assign wh      = wh_full[WH_W-1:0];

  // item latch
  logic             cmd_q;
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_data_i.command;
      pix_q <= in_data_i.pixel_in;
    end
  end

  // positions
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_nx, out_row_nx;
  logic [COL_W-1:0] in_col_nx, out_col_nx;

  function automatic logic [ROW_W+COL_W-1:0] step_pos(logic [ROW_W-1:0] row,
                                                      logic [COL_W-1:0] col,
                                                      logic [IW_W-1:0]  w,
                                                      logic [IH_W-1:0]  h);
    logic [IW_W-1:0]  c1;
    logic [ROW_W:0]   r1;
    logic [COL_W-1:0] c_o;
    logic [ROW_W-1:0] r_o;
    c1 = IW_W'(col) + IW_W'(1);
    r1 = {1'b0, row};
    c_o = c1[COL_W-1:0];
    if (c1 >= w) begin
      c_o = '0;
      r1  = r1 + 1'b1;
    end
    r_o = (IH_W'(r1) >= h) ? '0 : r1[ROW_W-1:0];
    return {r_o, c_o};
  endfunction

  assign {in_row_nx, in_col_nx}   = step_pos(in_row_q, in_col_q, eff_w, eff_h);
  assign {out_row_nx, out_col_nx} = step_pos(out_row_q, out_col_q, eff_w, eff_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      if (cmd_i.adv_in) begin
        in_row_q <= in_row_nx;
        in_col_q <= in_col_nx;
      end
      if (cmd_i.adv_out) begin
        out_row_q <= out_row_nx;
        out_col_q <= out_col_nx;
      end
    end
  end

  // line stores
  logic [PIX_W-1:0] up_mem [MEM_D];
  logic [PIX_W-1:0] lo_mem [MEM_D];
  logic [PIX_W-1:0] u_rd_q, l_rd_q;
  logic [IW_W-1:0]  dcol1;
  logic [COL_W-1:0] drain_col, rd_addr;

  assign dcol1     = IW_W'(out_col_q) + IW_W'(1);
  assign drain_col = (dcol1 >= eff_w) ? '0 : dcol1[COL_W-1:0];
  assign rd_addr   = (cmd_q == bf3_pkg::CMD_DRAIN) ? drain_col : in_col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      u_rd_q <= up_mem[rd_addr];
      l_rd_q <= lo_mem[rd_addr];
    end
    if (cmd_i.mem_write) begin
      up_mem[in_col_q] <= l_rd_q;
      lo_mem[in_col_q] <= pix_q;
    end
  end

  // linear position: (row*w + col) mod wh, reduced bit by bit when out of range
  logic [LIN_W-1:0]        prod_q, s_q, lin_in_q, lin_out_q;
  logic [K_W-1:0]          k_q;
  logic [ROW_W+IW_W-1:0]   prod_full;
  logic [LIN_W-1:0]        s_shr;
  logic [WH_W+RED_TOP-1:0] wh_shl;
  logic                    red_ge;

  assign prod_full = {{IW_W{1'b0}}, (cmd_i.lin_sel ? out_row_q : in_row_q)} *
                     {{ROW_W{1'b0}}, eff_w};
  assign s_shr  = s_q >> k_q;
  assign red_ge = {1'b0, s_shr} >= wh;
  assign wh_shl = {{RED_TOP{1'b0}}, wh} << k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lin_mul) begin
      prod_q <= prod_full[LIN_W-1:0];
    end
    if (cmd_i.lin_add) begin
      s_q <= prod_q + LIN_W'(cmd_i.lin_sel ? out_col_q : in_col_q);
      k_q <= K_W'(RED_TOP);
    end
    if (cmd_i.lin_red) begin
      if (red_ge) begin
        s_q <= s_q - wh_shl[LIN_W-1:0];
      end
      k_q <= k_q - 1'b1;
    end
    if (cmd_i.lin_store) begin
      if (cmd_i.lin_sel) begin
        lin_out_q <= s_q;
      end else begin
        lin_in_q <= s_q;
      end
    end
  end

  // emit decision
  logic [WH_W-1:0] pend;
  logic            emit, last_col, bot_row;

  always_comb begin
    if (lin_in_q >= lin_out_q) begin
      pend = WH_W'(lin_in_q) - WH_W'(lin_out_q);
    end else begin
      pend = WH_W'(lin_in_q) + wh - WH_W'(lin_out_q);
    end
    if (cmd_q == bf3_pkg::CMD_DRAIN) begin
      emit = (lin_in_q == '0) && (lin_out_q != '0);
    end else begin
      emit = (pend == (WH_W'(eff_w) + WH_W'(2)));
    end
  end

  assign last_col = dcol1 >= eff_w;
  assign bot_row  = (IH_W'(out_row_q) + IH_W'(1)) >= eff_h;

  // window
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] new_bot;

  assign new_bot = (cmd_q == bf3_pkg::CMD_DRAIN) ? '0 : pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (cmd_i.win_shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= u_rd_q;
      win_q[1][2] <= l_rd_q;
      win_q[2][2] <= new_bot;
    end
  end

  // weighted sums: stage 1 weight, stage 2 accumulate
  logic [1:0]        cc_q, lc_q, rc_q, t_q, b_q;
  logic              fe_q;
  logic [3:0]        j_q;
  logic              v1_q;
  logic [WT_W-1:0]   wt1_q;
  logic [PIX_W-1:0]  n1_q;
  logic [SW_W-1:0]   sw_q;
  logic [SWP_W-1:0]  swp_q;
  logic [1:0]        rsel, csel;
  logic [WT_W-1:0]   sp;
  logic [PIX_W-1:0]  c_pix, n_pix, dpix;
  logic [2*WT_W-1:0] wprod;

  always_comb begin
    rsel = 2'd1;
    csel = cc_q;
    sp   = bf3_pkg::CENTRE_WEIGHT;
    case (j_q)
      4'd0: begin rsel = 2'd1; csel = cc_q; sp = bf3_pkg::CENTRE_WEIGHT; end
      4'd1: begin rsel = t_q;  csel = cc_q; sp = edge_q; end
      4'd2: begin rsel = b_q;  csel = cc_q; sp = edge_q; end
      4'd3: begin rsel = 2'd1; csel = lc_q; sp = edge_q; end
      4'd4: begin rsel = 2'd1; csel = rc_q; sp = edge_q; end
      4'd5: begin rsel = t_q;  csel = lc_q; sp = corner_q; end
      4'd6: begin rsel = t_q;  csel = rc_q; sp = corner_q; end
      4'd7: begin rsel = b_q;  csel = lc_q; sp = corner_q; end
      4'd8: begin rsel = b_q;  csel = rc_q; sp = corner_q; end
      default: begin rsel = 2'd1; csel = cc_q; sp = bf3_pkg::CENTRE_WEIGHT; end
    endcase
  end

  assign c_pix = win_q[1][cc_q];
  assign n_pix = win_q[rsel][csel];
  assign dpix  = (c_pix > n_pix) ? (c_pix - n_pix) : (n_pix - c_pix);
  assign wprod = sp * bf3_pkg::RANGE_ROM[dpix];

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      t_q   <= (out_row_q == '0) ? 2'd2 : 2'd0;
      b_q   <= bot_row ? 2'd0 : 2'd2;
      fe_q  <= bot_row && last_col;
      if (last_col) begin
        cc_q <= 2'd2;
        lc_q <= 2'd1;
        rc_q <= 2'd1;
      end else begin
        cc_q <= 2'd1;
        lc_q <= (out_col_q == '0) ? 2'd2 : 2'd0;
        rc_q <= 2'd2;
      end
      sw_q  <= '0;
      swp_q <= '0;
      j_q   <= '0;
      v1_q  <= 1'b0;
    end
    if (cmd_i.acc_step) begin
      v1_q  <= (j_q < 4'd9);
      wt1_q <= wprod[2*WT_W-1:WT_W];
      n1_q  <= n_pix;
      j_q   <= j_q + 1'b1;
      if (v1_q) begin
        sw_q  <= sw_q + SW_W'(wt1_q);
        swp_q <= swp_q + (SWP_W'(wt1_q) * SWP_W'(n1_q));
      end
    end
  end

  // restoring divide, quotient is at most 255
  logic [SWP_W-1:0] rem_q;
  logic [PIX_W-1:0] q_q;
  logic [2:0]       dk_q;
  logic [SWP_W-1:0] rem_shr, sw_shl;

  assign rem_shr = rem_q >> dk_q;
  assign sw_shl  = SWP_W'(sw_q) << dk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= swp_q;
      q_q   <= '0;
      dk_q  <= 3'd7;
    end
    if (cmd_i.div_step) begin
      if (rem_shr >= SWP_W'(sw_q)) begin
        rem_q      <= rem_q - sw_shl;
        q_q[dk_q]  <= 1'b1;
      end
      dk_q <= dk_q - 1'b1;
    end
  end

  // output register
  logic     out_valid_q;
  bf3_pkg::bf3_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pixel_out <= (sw_q == '0) ? '0 : q_q;
      out_q.frame_end <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.is_drain = (cmd_q == bf3_pkg::CMD_DRAIN);
  assign stat_o.lin_fin  = {1'b0, s_q} < wh;
  assign stat_o.emit     = emit;
  assign stat_o.last_col = last_col;
  assign stat_o.acc_done = (j_q == 4'd9);
  assign stat_o.div_done = (dk_q == 3'd0);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

@@ sv/bilateral_filter_3x3.sv @@
// Channel | Signals                          | Direction | Moves
// in      | in_valid_i, in_stall_o, in_data_i | input     | command + pixel_in item
// out     | out_valid_o, out_stall_i, out_data_o | output | pixel_out + frame_end item
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i  | input     | register write, no wait
//
// One item at a time. A pixel that emits nothing does a line-store read and write
// and two position multiplies; an emitting item also passes nine weights through
// one shared 16x16 multiplier pipe, then an 8-step divider. A position left out of
// range by a geometry change needs extra reduction steps. Reset clears control,
// positions, window, configuration registers and output valid; line stores are
// not cleared. The next item is taken while a result waits in the output register.
module bilateral_filter_3x3 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bf3_pkg::bf3_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bf3_pkg::bf3_out_t              out_data_o
);

  // controller issues one command set per cycle, datapath answers with status
  bf3_pkg::bf3_cmd_t  cmd;
  bf3_pkg::bf3_stat_t stat;

  bf3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // line stores, window, position math, weight pipe, divider, output register
  bf3_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

@@ tb/bf3_scoreboard.sv @@
`timescale 1ns / 1ps

class bf3_scoreboard;
  logic [bf3_pkg::PIX_W-1:0] upper_line [bf3_pkg::MAX_WIDTH];
  logic [bf3_pkg::PIX_W-1:0] lower_line [bf3_pkg::MAX_WIDTH];
  logic [bf3_pkg::PIX_W-1:0] win [3][3];
  logic [bf3_pkg::WT_W-1:0]  range_wt [256];
  int unsigned in_row, in_col, out_row, out_col;
  int unsigned reg_width, reg_height, reg_edge, reg_corner;
  bf3_pkg::bf3_out_t expected_pix[$];
  int          errors;

  function new();
    longint unsigned m, e1, v, n, q, rnd;
    m = 2 * bf3_pkg::RANGE_SIGMA * bf3_pkg::RANGE_SIGMA;
    e1 = exp_series(1, 1);
    for (int d = 0; d < 256; d++) begin
      n = d * d;
      q = n / m;
      if (q >= 12) begin
        range_wt[d] = '0;
      end else begin
        v = exp_series(n % m, m);
        for (longint unsigned i = 0; i < q; i++) v = q40_mul(v, e1);
        rnd = (v * 65535 + (64'd1 << 39)) >> 40;
        range_wt[d] = (rnd > 65535) ? 16'hFFFF : rnd[15:0];
      end
    end
    for (int i = 0; i < bf3_pkg::MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    reg_width = 256; reg_height = 256; reg_edge = 65535; reg_corner = 65535;
    errors = 0;
  endfunction

  // floor(a*b/c) without overflowing 64 bits
  function longint unsigned scaled_div(longint unsigned a, longint unsigned b,
                                       longint unsigned c);
    longint unsigned hi, q1, r1, x;
    hi = (a >> 20) * b;
    q1 = hi / c;
    r1 = hi % c;
    x  = (r1 << 20) + (a & 64'hFFFFF) * b;
    return (q1 << 20) + x / c;
  endfunction

  function longint unsigned q40_mul(longint unsigned a, longint unsigned b);
    return ((a * (b >> 20)) + ((a * (b & 64'hFFFFF)) >> 20)) >> 20;
  endfunction

  // exp(-r/m) in Q.40 by Taylor series
  function longint unsigned exp_series(longint unsigned r, longint unsigned m);
    longint unsigned term;
    longint          sum;
    term = 64'd1 << 40;
    sum  = longint'(term);
    for (int k = 1; k <= 30; k++) begin
      term = scaled_div(term, r, m * k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return (sum < 0) ? 64'd0 : $unsigned(sum);
  endfunction

  function void write_reg(logic [bf3_pkg::CFG_IDX_W-1:0] idx,
                          logic [bf3_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bf3_pkg::CFG_IMAGE_WIDTH:   reg_width  = val & 16'h07FF;
      bf3_pkg::CFG_IMAGE_HEIGHT:  reg_height = val & 16'h1FFF;
      bf3_pkg::CFG_EDGE_WEIGHT:   reg_edge   = val;
      bf3_pkg::CFG_CORNER_WEIGHT: reg_corner = val;
      default: ;
    endcase
  endfunction

  function int unsigned frame_w();
    return (reg_width < bf3_pkg::MIN_DIM) ? bf3_pkg::MIN_DIM :
           (reg_width > bf3_pkg::MAX_WIDTH) ? bf3_pkg::MAX_WIDTH : reg_width;
  endfunction

  function int unsigned frame_h();
    return (reg_height < bf3_pkg::MIN_DIM) ? bf3_pkg::MIN_DIM :
           (reg_height > bf3_pkg::MAX_HEIGHT) ? bf3_pkg::MAX_HEIGHT : reg_height;
  endfunction

  function longint unsigned raster_idx(int unsigned r, int unsigned c);
    return (longint'(r) * frame_w() + c) % (longint'(frame_w()) * frame_h());
  endfunction

  function void step_pos(ref int unsigned r, ref int unsigned c);
    c++;
    if (c >= frame_w()) begin
      c = 0;
      r++;
    end
    if (r >= frame_h()) r = 0;
  endfunction

  function void add_tap(int unsigned s, logic [7:0] c, logic [7:0] nb,
                        ref longint unsigned sw, ref longint unsigned swp);
    int unsigned     d;
    longint unsigned wt;
    d   = (c > nb) ? c - nb : nb - c;
    wt  = (longint'(s) * range_wt[d]) >> 16;
    sw  += wt;
    swp += wt * nb;
  endfunction

  function logic [7:0] weighted_mean(int cc, int lc, int rc);
    int              t, b;
    logic [7:0]      c;
    longint unsigned sw, swp, r;
    // mirrored rows at the top and bottom of the frame
    t = (out_row == 0) ? 2 : 0;
    b = (out_row + 1 >= frame_h()) ? 0 : 2;
    c = win[1][cc];
    sw = 0;
    swp = 0;
    add_tap(65535, c, c, sw, swp);
    add_tap(reg_edge, c, win[t][cc], sw, swp);
    add_tap(reg_edge, c, win[b][cc], sw, swp);
    add_tap(reg_edge, c, win[1][lc], sw, swp);
    add_tap(reg_edge, c, win[1][rc], sw, swp);
    add_tap(reg_corner, c, win[t][lc], sw, swp);
    add_tap(reg_corner, c, win[t][rc], sw, swp);
    add_tap(reg_corner, c, win[b][lc], sw, swp);
    add_tap(reg_corner, c, win[b][rc], sw, swp);
    r = (sw == 0) ? 0 : swp / sw;
    return (r > 255) ? 8'hFF : r[7:0];
  endfunction

  function void shift_window(logic [7:0] u, logic [7:0] l, logic [7:0] p, bit emit);
    bit                last_col;
    bf3_pkg::bf3_out_t res;
    last_col = (out_col + 1 >= frame_w());
    res = '0;
    // last column mirrors the column to its left, taken before the shift
    if (emit && last_col) res.pixel_out = weighted_mean(2, 1, 1);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = u;
    win[1][2] = l;
    win[2][2] = p;
    if (!emit) return;
    if (!last_col) res.pixel_out = weighted_mean(1, (out_col == 0) ? 2 : 0, 2);
    res.frame_end = (out_row + 1 >= frame_h()) && last_col;
    expected_pix.push_back(res);
    step_pos(out_row, out_col);
  endfunction

  function void note_input(bf3_pkg::bf3_in_t it);
    longint unsigned wh, pend;
    int unsigned     col;
    logic [7:0]      u, l;
    wh = longint'(frame_w()) * frame_h();
    if (it.command == bf3_pkg::CMD_PIXEL) begin
      col = in_col % bf3_pkg::MAX_WIDTH;
      u = upper_line[col];
      l = lower_line[col];
      upper_line[col] = l;
      lower_line[col] = it.pixel_in;
      step_pos(in_row, in_col);
      pend = (raster_idx(in_row, in_col) + wh - raster_idx(out_row, out_col)) % wh;
      shift_window(u, l, it.pixel_in, pend == frame_w() + 2);
    end else begin
      // drain only acts at the frame boundary with outputs still owed
      if (raster_idx(in_row, in_col) != 0) return;
      if (raster_idx(out_row, out_col) == 0) return;
      col = out_col + 1;
      if (col >= frame_w()) col = 0;
      col = col % bf3_pkg::MAX_WIDTH;
      shift_window(upper_line[col], lower_line[col], 8'd0, 1'b1);
    end
  endfunction

  function void check(bf3_pkg::bf3_out_t got);
    bf3_pkg::bf3_out_t exp_item;
    if (expected_pix.size() == 0) begin
      $display("%0t: unexpected item pixel_out=%0d frame_end=%0d",
               $realtime, got.pixel_out, got.frame_end);
      errors++;
      return;
    end
    exp_item = expected_pix.pop_front();
    if (got.pixel_out !== exp_item.pixel_out) begin
      $display("%0t: pixel_out expected %0d actual %0d",
               $realtime, exp_item.pixel_out, got.pixel_out);
      errors++;
    end
    if (got.frame_end !== exp_item.frame_end) begin
      $display("%0t: frame_end expected %0d actual %0d",
               $realtime, exp_item.frame_end, got.frame_end);
      errors++;
    end
  endfunction
endclass

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int SETTLE_CYCLES = 200;   // covers a non-emitting item plus reductions
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off for back-pressure

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  bf3_pkg::bf3_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  bf3_pkg::bf3_out_t              out_data;

  bf3_scoreboard sb;
  int            items_sent;
  int            snd_idle, rcv_idle;  // percent of cycles idled
  bit            in_calm_phase;
  int unsigned   cur_w, cur_h;
  longint        cycles;

  bilateral_filter_3x3 u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("bilateral_filter_3x3 test failed");
        $finish;
      end
    end
  end

  // output side: random stall, plus one long hold-off when the calm phase starts
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && in_calm_phase) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  // result checking; DUT outputs update in the NBA region, so posedge sampling is safe
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check(out_data);
  end

  // drive one item, optionally idling first; returns just after the accepting edge
  task automatic send_item(logic cmd, logic [7:0] pix);
    bf3_pkg::bf3_in_t it;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    it.command  = cmd;
    it.pixel_in = pix;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(it);
    items_sent++;
    // idling schedule: receiver-heavy, then sender-heavy, then quiet
    if (items_sent < 600) begin
      snd_idle = 12; rcv_idle = 47;
    end else if (items_sent < 1200) begin
      snd_idle = 47; rcv_idle = 12;
    end else begin
      snd_idle = 0; rcv_idle = 0; in_calm_phase = 1'b1;
    end
  endtask

  // wait for every expected item, then let stragglers finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pix.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all four registers back to back; block must be idle
  task automatic set_config(int unsigned w, int unsigned h, int unsigned ew, int unsigned cw);
    logic [bf3_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [bf3_pkg::CFG_DATA_W-1:0] val [4];
    idx = '{bf3_pkg::CFG_IMAGE_WIDTH, bf3_pkg::CFG_IMAGE_HEIGHT,
            bf3_pkg::CFG_EDGE_WEIGHT, bf3_pkg::CFG_CORNER_WEIGHT};
    val = '{w[bf3_pkg::CFG_DATA_W-1:0], h[bf3_pkg::CFG_DATA_W-1:0],
            ew[bf3_pkg::CFG_DATA_W-1:0], cw[bf3_pkg::CFG_DATA_W-1:0]};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
      sb.write_reg(idx[i], val[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cur_w = sb.frame_w();
    cur_h = sb.frame_h();
  endtask

  // one frame of pixels with stray drain ticks mixed in, then a flush
  task automatic run_frame(int style, bit full_flush);
    logic [7:0] pix;
    int         n_drain;
    for (int i = 0; i < cur_w * cur_h; i++) begin
      if ($urandom_range(19) == 0) send_item(bf3_pkg::CMD_DRAIN, 8'($urandom_range(255)));
      case (style)
        0: pix = 8'($urandom_range(255));
        1: pix = $urandom_range(1) ? 8'hFF : 8'h00;
        default: pix = 8'((i % cur_w) * 16 + $urandom_range(15));
      endcase
      send_item(bf3_pkg::CMD_PIXEL, pix);
    end
    // a partial flush lets the next frame push out the remaining outputs
    n_drain = full_flush ? cur_w + 1 : $urandom_range(cur_w + 1);
    repeat (n_drain) send_item(bf3_pkg::CMD_DRAIN, 8'($urandom_range(255)));
  endtask

  function automatic int unsigned pick_weight();
    case ($urandom_range(3))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  initial begin : stimulus
    logic [7:0] corner_pix [9];
    bit         flush;
    sb = new();
    items_sent = 0;
    snd_idle = 12;
    rcv_idle = 47;
    in_calm_phase = 1'b0;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = bf3_pkg::CFG_IMAGE_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: smallest frame (width and height saturated up), extreme weights
    set_config(0, 0, 65535, 0);
    send_item(bf3_pkg::CMD_DRAIN, 8'hFF);  // nothing pending: no result
    corner_pix = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00};
    foreach (corner_pix[i]) send_item(bf3_pkg::CMD_PIXEL, corner_pix[i]);
    repeat (5) send_item(bf3_pkg::CMD_DRAIN, 8'h00);  // last one finds nothing to flush
    settle();
    set_config(3, 3, 0, 65535);
    for (int i = 0; i < 9; i++) send_item(bf3_pkg::CMD_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
    repeat (4) send_item(bf3_pkg::CMD_DRAIN, 8'h55);

    // random frames; geometry only changes after a complete flush
    while (items_sent < 820) begin
      flush = ($urandom_range(2) != 0);
      run_frame($urandom_range(2), flush);
      if (flush && $urandom_range(1)) begin
        settle();
        set_config($urandom_range(3) == 0 ? $urandom_range(3) : $urandom_range(3, 12),
                   $urandom_range(4) == 0 ? $urandom_range(2) : $urandom_range(3, 8),
                   pick_weight(), pick_weight());
      end
    end

    // one more frame, then one wide frame: line stores far past the small random widths
    run_frame(0, 1'b1);
    settle();
    set_config(160, 3, pick_weight(), pick_weight());
    run_frame(0, 1'b1);
    settle();

    if (sb.errors == 0) begin
      $display("bilateral_filter_3x3 test passed");
    end else begin
      $display("bilateral_filter_3x3 test failed");
    end
    $finish;
  end
endmodule
